>>> design/nmea_gga_position_parser_defines.svh
// ----------------------------------------------------------------------------
// nmea gga position parser assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_POSITION_PARSER_DEFINES_SVH
`define NMEA_GGA_POSITION_PARSER_DEFINES_SVH

// same-cycle implication
`define NGGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NGGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ngga_pkg.sv
// ----------------------------------------------------------------------------
// nmea gga position parser package
// beat payload types for the byte and fix channels
// ----------------------------------------------------------------------------
package ngga_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_t;

  typedef struct packed {
    logic [6:0]  fix_hour;
    logic [6:0]  fix_minute;
    logic [16:0] fix_sec_milli;
    logic [6:0]  lat_degrees;
    logic [19:0] lat_min_e4;
    logic        lat_south;
    logic [9:0]  lon_degrees;
    logic [19:0] lon_min_e4;
    logic        lon_west;
    logic [3:0]  fix_quality;
    logic        fix_updated;
    logic        has_fix;
  } fix_t;

endpackage

>>> design/ngga_stream_if.sv
// ----------------------------------------------------------------------------
// nmea gga stream interface
// valid/ready channel carrying one payload beat per handshake
// ----------------------------------------------------------------------------
interface ngga_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/nmea_gga_position_parser.sv
// ----------------------------------------------------------------------------
// nmea gga position parser
// extracts time, position and fix quality from a gga sentence byte stream
// ----------------------------------------------------------------------------
// rx carries one received character per beat; fix returns one beat for every
// rx beat, holding the last committed position record, with fix_updated set on
// the beat whose byte was a valid quality digit that closed a sentence.
// the path is an input byte register followed by the parser, whose committed
// record doubles as the fix output register.
// a byte taken on rx is held in the input byte register and then folded into
// the committed record, which drives fix; a stall on fix holds it in between.
// throughput: one byte per cycle while fix is not stalled, since the field
// update between the byte register and the result register is combinational.
// reset (rst, synchronous) empties both registers, sends the parser hunting
// for the start character and clears the committed record to all zero.
// when fix stalls, the result waits in place and rx still takes one more byte
// into the input register; rx ready drops only when both are full.
// ----------------------------------------------------------------------------
module nmea_gga_position_parser (
  input  logic          clk,
  input  logic          rst,
  ngga_stream_if.sink   rx,
  ngga_stream_if.source fix
);

  ngga_stream_if #(.payload_t(ngga_pkg::rx_t)) byte_ch ();

  ngga_byte_stage u_byte_stage (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (rx),
    .out_ch (byte_ch.source)
  );

  ngga_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch.sink),
    .out_ch (fix)
  );

endmodule

>>> design/ngga_byte_stage.sv
// ----------------------------------------------------------------------------
// nmea gga byte input stage
// registers one received byte beat in front of the parser
// ----------------------------------------------------------------------------
module ngga_byte_stage (
  input  logic          clk,
  input  logic          rst,
  ngga_stream_if.sink   in_ch,
  ngga_stream_if.source out_ch
);

  logic          held_valid;
  ngga_pkg::rx_t held_data;

  assign in_ch.ready  = !held_valid || out_ch.ready;
  assign out_ch.valid = held_valid;
  assign out_ch.data  = held_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ch.ready) begin
      held_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      held_data <= in_ch.data;
    end
  end

endmodule

>>> design/ngga_parser.sv
// ----------------------------------------------------------------------------
// nmea gga sentence parser core
// positional field state machine, working record and committed fix register
// ----------------------------------------------------------------------------
`include "nmea_gga_position_parser_defines.svh"

module ngga_parser (
  input  logic          clk,
  input  logic          rst,
  ngga_stream_if.sink   in_ch,
  ngga_stream_if.source out_ch
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_TIME, PH_LAT, PH_NS, PH_LON, PH_EW, PH_QUAL
  } phase_t;

  typedef enum logic [2:0] {
    T_DOT, T_HOUR, T_MIN, T_SEC, T_LATD, T_LATM, T_LOND, T_LONM
  } target_t;

  typedef struct packed {
    target_t     target;
    logic [16:0] weight;
  } slot_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [3:0] HDR_LEN   = 4'd5;
  localparam logic [3:0] HDR_LAST  = 4'd4;
  localparam logic [3:0] LAT_LAST  = 4'd8;
  localparam logic [3:0] FLD_LAST  = 4'd9;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd1:    c = CH_N;
      3'd4:    c = CH_A;
      default: c = CH_G;
    endcase
    return c;
  endfunction

  function automatic slot_t slot_lookup(input phase_t ph, input logic [3:0] idx);
    slot_t s;
    s = '{target: T_DOT, weight: 17'd0};
    unique case (ph)
      PH_TIME: begin
        case (idx)
          4'd0:    s = '{target: T_HOUR, weight: 17'd10};
          4'd1:    s = '{target: T_HOUR, weight: 17'd1};
          4'd2:    s = '{target: T_MIN,  weight: 17'd10};
          4'd3:    s = '{target: T_MIN,  weight: 17'd1};
          4'd4:    s = '{target: T_SEC,  weight: 17'd10000};
          4'd5:    s = '{target: T_SEC,  weight: 17'd1000};
          4'd7:    s = '{target: T_SEC,  weight: 17'd100};
          4'd8:    s = '{target: T_SEC,  weight: 17'd10};
          4'd9:    s = '{target: T_SEC,  weight: 17'd1};
          default: s = '{target: T_DOT,  weight: 17'd0};
        endcase
      end
      PH_LAT: begin
        case (idx)
          4'd0:    s = '{target: T_LATD, weight: 17'd10};
          4'd1:    s = '{target: T_LATD, weight: 17'd1};
          4'd2:    s = '{target: T_LATM, weight: 17'd100000};
          4'd3:    s = '{target: T_LATM, weight: 17'd10000};
          4'd5:    s = '{target: T_LATM, weight: 17'd1000};
          4'd6:    s = '{target: T_LATM, weight: 17'd100};
          4'd7:    s = '{target: T_LATM, weight: 17'd10};
          4'd8:    s = '{target: T_LATM, weight: 17'd1};
          default: s = '{target: T_DOT,  weight: 17'd0};
        endcase
      end
      PH_LON: begin
        case (idx)
          4'd0:    s = '{target: T_LOND, weight: 17'd100};
          4'd1:    s = '{target: T_LOND, weight: 17'd10};
          4'd2:    s = '{target: T_LOND, weight: 17'd1};
          4'd3:    s = '{target: T_LONM, weight: 17'd100000};
          4'd4:    s = '{target: T_LONM, weight: 17'd10000};
          4'd6:    s = '{target: T_LONM, weight: 17'd1000};
          4'd7:    s = '{target: T_LONM, weight: 17'd100};
          4'd8:    s = '{target: T_LONM, weight: 17'd10};
          4'd9:    s = '{target: T_LONM, weight: 17'd1};
          default: s = '{target: T_DOT,  weight: 17'd0};
        endcase
      end
      default: s = '{target: T_DOT, weight: 17'd0};
    endcase
    return s;
  endfunction

  phase_t           phase;
  phase_t           phase_next;
  logic [3:0]       char_index;
  logic [3:0]       char_index_next;
  ngga_pkg::fix_t   work;
  ngga_pkg::fix_t   work_next;
  ngga_pkg::fix_t   fix;
  ngga_pkg::fix_t   fix_next;
  logic             fix_valid;

  logic             take;
  logic [7:0]       b;
  logic [7:0]       b_off;
  logic [3:0]       digit;
  logic             is_digit;
  logic             ignored;
  slot_t            slot;
  logic [3:0]       last;
  logic [20:0]      prod;

  assign in_ch.ready  = !fix_valid || out_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = fix_valid;
  assign out_ch.data  = fix;

  assign b        = in_ch.data.rx_byte;
  assign b_off    = b - CH_ZERO;
  assign digit    = b_off[3:0];
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign ignored  = (b == CH_COMMA) || (b == CH_LF) || (b == CH_CR);
  assign slot     = slot_lookup(phase, char_index);
  assign last     = (phase == PH_LAT) ? LAT_LAST : FLD_LAST;
  assign prod     = 21'(digit) * 21'(slot.weight);

  always_comb begin
    phase_next           = phase;
    char_index_next      = char_index;
    work_next            = work;
    fix_next             = fix;
    fix_next.fix_updated = 1'b0;
    if (!ignored) begin
      unique case (phase)
        PH_HUNT: begin
          if (b == CH_DOLLAR) begin
            phase_next      = PH_HEADER;
            char_index_next = 4'd0;
          end
        end
        PH_HEADER: begin
          if ((char_index < HDR_LEN) && (hdr_char(char_index[2:0]) == b)) begin
            if (char_index == HDR_LAST) begin
              work_next       = '0;
              phase_next      = PH_TIME;
              char_index_next = 4'd0;
            end else begin
              char_index_next = char_index + 4'd1;
            end
          end else begin
            phase_next      = PH_HUNT;
            char_index_next = 4'd0;
          end
        end
        PH_TIME, PH_LAT, PH_LON: begin
          if ((char_index > last) || ((slot.target != T_DOT) && !is_digit)) begin
            phase_next      = PH_HUNT;
            char_index_next = 4'd0;
          end else begin
            case (slot.target)
              T_HOUR: work_next.fix_hour      = work.fix_hour + prod[6:0];
              T_MIN:  work_next.fix_minute    = work.fix_minute + prod[6:0];
              T_SEC:  work_next.fix_sec_milli = work.fix_sec_milli + prod[16:0];
              T_LATD: work_next.lat_degrees   = work.lat_degrees + prod[6:0];
              T_LATM: work_next.lat_min_e4    = work.lat_min_e4 + prod[19:0];
              T_LOND: work_next.lon_degrees   = work.lon_degrees + prod[9:0];
              T_LONM: work_next.lon_min_e4    = work.lon_min_e4 + prod[19:0];
              default: ;
            endcase
            if (char_index == last) begin
              char_index_next = 4'd0;
              case (phase)
                PH_TIME: phase_next = PH_LAT;
                PH_LAT:  phase_next = PH_NS;
                default: phase_next = PH_EW;
              endcase
            end else begin
              char_index_next = char_index + 4'd1;
            end
          end
        end
        PH_NS: begin
          char_index_next = 4'd0;
          if ((b == CH_N) || (b == CH_S)) begin
            work_next.lat_south = (b == CH_S);
            phase_next          = PH_LON;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_EW: begin
          char_index_next = 4'd0;
          if ((b == CH_E) || (b == CH_W)) begin
            work_next.lon_west = (b == CH_W);
            phase_next         = PH_QUAL;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_QUAL: begin
          if ((b >= CH_ZERO) && (b <= CH_EIGHT)) begin
            work_next.fix_quality = digit;
            fix_next              = work;
            fix_next.fix_quality  = digit;
            fix_next.fix_updated  = 1'b1;
            fix_next.has_fix      = (digit != 4'd0);
          end
          phase_next      = PH_HUNT;
          char_index_next = 4'd0;
        end
        default: begin
          phase_next      = PH_HUNT;
          char_index_next = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      char_index <= 4'd0;
      work       <= '0;
      fix        <= '0;
      fix_valid  <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      char_index <= char_index_next;
      work       <= work_next;
      fix        <= fix_next;
      fix_valid  <= 1'b1;
    end else if (out_ch.ready) begin
      fix_valid  <= 1'b0;
    end
  end

  `NGGA_ASSERT_NEXT(a_qual_ends_sentence, take && (phase == PH_QUAL) && !ignored,
    phase == PH_HUNT, "quality byte did not return parser to hunt")
  `NGGA_ASSERT_NEXT(a_commit_only_on_qual, take && (phase != PH_QUAL),
    !fix.fix_updated, "fix committed outside the quality position")
  `NGGA_ASSERT_NEXT(a_hold_without_commit, take && !fix_next.fix_updated,
    (fix.lat_min_e4 == $past(fix.lat_min_e4)) && (fix.fix_quality == $past(fix.fix_quality)),
    "committed record changed without a commit")
  `NGGA_ASSERT_NOW(a_index_bound, 1'b1, char_index <= FLD_LAST,
    "character index beyond the longest field")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// nmea gga position parser testbench
// streams gga sentences, broken sentences and noise into the parser and checks
// every fix beat against a byte-by-byte model of the sentence state machine
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [2:0] {
    ST_HUNT, ST_HEADER, ST_TIME, ST_LAT, ST_NS, ST_LON, ST_EW, ST_QUAL
  } parse_state_e;

  typedef enum logic [2:0] {
    D_DOT, D_HOUR, D_MIN, D_SEC, D_LATD, D_LATM, D_LOND, D_LONM
  } digit_dest_e;

  typedef struct packed {
    digit_dest_e dest;
    logic [19:0] weight;
  } slot_t;

  typedef enum {LAYOUT_TIDY, LAYOUT_ODD_DOTS, LAYOUT_LOOSE} layout_e;

  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_EIGHT  = "8";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_N      = "N";
  localparam logic [7:0] CH_S      = "S";
  localparam logic [7:0] CH_E      = "E";
  localparam logic [7:0] CH_W      = "W";
  localparam logic [39:0] HEADER_TEXT = "GNGGA";
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst;

  ngga_stream_if #(.payload_t(ngga_pkg::rx_t))  byte_ch ();
  ngga_stream_if #(.payload_t(ngga_pkg::fix_t)) fix_ch ();

  nmea_gga_position_parser DUT (
    .clk (clk),
    .rst (rst),
    .rx  (byte_ch),
    .fix (fix_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]     byte_pending [$];
  ngga_pkg::fix_t fix_expected [$];
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_left = 0;
  logic           hold_start = 1'b0;
  logic           hold_done = 1'b0;
  int             failures = 0;
  int             stall_cycles = 0;

  // parser model state
  parse_state_e   parse_state = ST_HUNT;
  logic [3:0]     char_idx = '0;
  ngga_pkg::fix_t work_rec = '0;
  ngga_pkg::fix_t committed_rec = '0;

  function automatic slot_t slot_at(parse_state_e st, logic [3:0] idx);
    slot_t s;
    s = '{D_DOT, 20'd0};
    case (st)
      ST_TIME: begin
        case (idx)
          0: s = '{D_HOUR, 20'd10};
          1: s = '{D_HOUR, 20'd1};
          2: s = '{D_MIN, 20'd10};
          3: s = '{D_MIN, 20'd1};
          4: s = '{D_SEC, 20'd10000};
          5: s = '{D_SEC, 20'd1000};
          6: s = '{D_DOT, 20'd0};
          7: s = '{D_SEC, 20'd100};
          8: s = '{D_SEC, 20'd10};
          default: s = '{D_SEC, 20'd1};
        endcase
      end
      ST_LAT: begin
        case (idx)
          0: s = '{D_LATD, 20'd10};
          1: s = '{D_LATD, 20'd1};
          2: s = '{D_LATM, 20'd100000};
          3: s = '{D_LATM, 20'd10000};
          4: s = '{D_DOT, 20'd0};
          5: s = '{D_LATM, 20'd1000};
          6: s = '{D_LATM, 20'd100};
          7: s = '{D_LATM, 20'd10};
          default: s = '{D_LATM, 20'd1};
        endcase
      end
      default: begin
        case (idx)
          0: s = '{D_LOND, 20'd100};
          1: s = '{D_LOND, 20'd10};
          2: s = '{D_LOND, 20'd1};
          3: s = '{D_LONM, 20'd100000};
          4: s = '{D_LONM, 20'd10000};
          5: s = '{D_DOT, 20'd0};
          6: s = '{D_LONM, 20'd1000};
          7: s = '{D_LONM, 20'd100};
          8: s = '{D_LONM, 20'd10};
          default: s = '{D_LONM, 20'd1};
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic void back_to_hunt();
    parse_state = ST_HUNT;
    char_idx = '0;
  endfunction

  // one byte of a positional number, true when its last position is taken
  function automatic logic number_byte(logic [7:0] b, logic [3:0] last);
    slot_t       s;
    logic [31:0] v;
    if (char_idx > last) begin
      back_to_hunt();
      return 1'b0;
    end
    s = slot_at(parse_state, char_idx);
    if (s.dest != D_DOT) begin
      if (b < CH_ZERO || b > CH_NINE) begin
        back_to_hunt();
        return 1'b0;
      end
      v = (32'(b) - 32'(CH_ZERO)) * 32'(s.weight);
      case (s.dest)
        D_HOUR: work_rec.fix_hour = work_rec.fix_hour + v[6:0];
        D_MIN:  work_rec.fix_minute = work_rec.fix_minute + v[6:0];
        D_SEC:  work_rec.fix_sec_milli = work_rec.fix_sec_milli + v[16:0];
        D_LATD: work_rec.lat_degrees = work_rec.lat_degrees + v[6:0];
        D_LATM: work_rec.lat_min_e4 = work_rec.lat_min_e4 + v[19:0];
        D_LOND: work_rec.lon_degrees = work_rec.lon_degrees + v[9:0];
        D_LONM: work_rec.lon_min_e4 = work_rec.lon_min_e4 + v[19:0];
        default: ;
      endcase
    end
    if (char_idx == last) begin
      char_idx = '0;
      return 1'b1;
    end
    char_idx = char_idx + 4'd1;
    return 1'b0;
  endfunction

  task automatic advance_parser(input logic [7:0] b);
    ngga_pkg::fix_t beat;
    logic updated;
    updated = 1'b0;
    if (b != CH_COMMA && b != CH_CR && b != CH_LF) begin
      case (parse_state)
        ST_HUNT: begin
          if (b == CH_DOLLAR) begin
            parse_state = ST_HEADER;
            char_idx = '0;
          end
        end
        ST_HEADER: begin
          if (char_idx < 4'd5 && HEADER_TEXT[8 * (4 - char_idx) +: 8] == b) begin
            if (char_idx == 4'd4) begin
              work_rec = '0;
              parse_state = ST_TIME;
              char_idx = '0;
            end else begin
              char_idx = char_idx + 4'd1;
            end
          end else begin
            back_to_hunt();
          end
        end
        ST_TIME: if (number_byte(b, 4'd9)) parse_state = ST_LAT;
        ST_LAT:  if (number_byte(b, 4'd8)) parse_state = ST_NS;
        ST_NS: begin
          if (b == CH_N || b == CH_S) begin
            work_rec.lat_south = (b == CH_S);
            parse_state = ST_LON;
            char_idx = '0;
          end else begin
            back_to_hunt();
          end
        end
        ST_LON:  if (number_byte(b, 4'd9)) parse_state = ST_EW;
        ST_EW: begin
          if (b == CH_E || b == CH_W) begin
            work_rec.lon_west = (b == CH_W);
            parse_state = ST_QUAL;
            char_idx = '0;
          end else begin
            back_to_hunt();
          end
        end
        default: begin
          if (b >= CH_ZERO && b <= CH_EIGHT) begin
            work_rec.fix_quality = 4'(b - CH_ZERO);
            committed_rec = work_rec;
            updated = 1'b1;
          end
          back_to_hunt();
        end
      endcase
    end
    beat = committed_rec;
    beat.fix_updated = updated;
    beat.has_fix = (committed_rec.fix_quality != 4'd0);
    fix_expected.push_back(beat);
  endtask

  // sentence building
  function automatic logic [7:0] solid_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] pick_digit(int fill);
    if (fill < 0) return CH_ZERO + 8'($urandom_range(0, 9));
    return CH_ZERO + 8'(fill);
  endfunction

  task automatic append_text(ref logic [7:0] s[$], input string t);
    foreach (t[i]) s.push_back(t[i]);
  endtask

  task automatic put_sep(ref logic [7:0] s[$], input layout_e layout);
    int n;
    int pick;
    if (layout != LAYOUT_LOOSE) begin
      s.push_back(CH_COMMA);
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        pick = $urandom_range(0, 5);
        s.push_back(pick == 0 ? CH_CR : pick == 1 ? CH_LF : CH_COMMA);
      end
    end
  endtask

  task automatic put_number(ref logic [7:0] s[$], input int whole, input int frac,
                            input int fill, input layout_e layout);
    repeat (whole) s.push_back(pick_digit(fill));
    if (layout == LAYOUT_ODD_DOTS || (layout == LAYOUT_LOOSE && $urandom_range(0, 5) == 0))
      s.push_back(solid_byte());
    else
      s.push_back(CH_DOT);
    repeat (frac) s.push_back(pick_digit(fill));
  endtask

  task automatic build_sentence(input int fill, input logic south, input logic west,
                                input logic [7:0] qual, input layout_e layout,
                                output logic [7:0] s[$], output int digit_pos,
                                output int ns_pos, output int ew_pos);
    s = {};
    s.push_back(CH_DOLLAR);
    for (int i = 0; i < 5; i++) s.push_back(HEADER_TEXT[8 * (4 - i) +: 8]);
    put_sep(s, layout);
    digit_pos = s.size();
    put_number(s, 6, 3, fill, layout);
    put_sep(s, layout);
    put_number(s, 4, 4, fill, layout);
    put_sep(s, layout);
    ns_pos = s.size();
    s.push_back(south ? CH_S : CH_N);
    put_sep(s, layout);
    put_number(s, 5, 4, fill, layout);
    put_sep(s, layout);
    ew_pos = s.size();
    s.push_back(west ? CH_W : CH_E);
    put_sep(s, layout);
    s.push_back(qual);
    append_text(s, ",08,0.9,545.4,M,,*47\r\n");
  endtask

  task automatic queue_random_traffic(input int budget);
    int         sent;
    int         kind;
    int         fill;
    int         dp;
    int         np;
    int         ep;
    layout_e    layout;
    logic [7:0] qual;
    logic [7:0] s[$];
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      fill = $urandom_range(0, 19);
      fill = (fill == 0) ? 0 : (fill == 1) ? 9 : -1;
      layout = ($urandom_range(0, 9) < 4) ? LAYOUT_TIDY :
               ($urandom_range(0, 9) == 0) ? LAYOUT_ODD_DOTS : LAYOUT_LOOSE;
      qual = ($urandom_range(0, 9) == 0) ? solid_byte() : CH_ZERO + 8'($urandom_range(0, 8));
      build_sentence(fill, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), qual, layout,
                     s, dp, np, ep);
      if (kind >= 85) begin
        s = {};
        if ($urandom_range(0, 1) == 1) append_text(s, "$GNG");
        repeat ($urandom_range(3, 20)) s.push_back(8'($urandom_range(0, 255)));
      end else if (kind >= 70) begin
        s[$urandom_range(1, s.size() - 1)] = 8'($urandom_range(0, 255));
      end
      sent += s.size();
      byte_pending = {byte_pending, s};
    end
  endtask

  task automatic drain();
    while (byte_pending.size() != 0 || fix_expected.size() != 0 || byte_ch.valid)
      @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      failures++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_beat(input ngga_pkg::fix_t exp_b, input ngga_pkg::fix_t act_b);
    check_field("fix_hour", 32'(exp_b.fix_hour), 32'(act_b.fix_hour));
    check_field("fix_minute", 32'(exp_b.fix_minute), 32'(act_b.fix_minute));
    check_field("fix_sec_milli", 32'(exp_b.fix_sec_milli), 32'(act_b.fix_sec_milli));
    check_field("lat_degrees", 32'(exp_b.lat_degrees), 32'(act_b.lat_degrees));
    check_field("lat_min_e4", 32'(exp_b.lat_min_e4), 32'(act_b.lat_min_e4));
    check_field("lat_south", 32'(exp_b.lat_south), 32'(act_b.lat_south));
    check_field("lon_degrees", 32'(exp_b.lon_degrees), 32'(act_b.lon_degrees));
    check_field("lon_min_e4", 32'(exp_b.lon_min_e4), 32'(act_b.lon_min_e4));
    check_field("lon_west", 32'(exp_b.lon_west), 32'(act_b.lon_west));
    check_field("fix_quality", 32'(exp_b.fix_quality), 32'(act_b.fix_quality));
    check_field("fix_updated", 32'(exp_b.fix_updated), 32'(act_b.fix_updated));
    check_field("has_fix", 32'(exp_b.has_fix), 32'(act_b.has_fix));
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data  <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) advance_parser(byte_ch.data.rx_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          byte_ch.valid <= 1'b1;
          byte_ch.data <= byte_pending.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // fix monitor
  always @(posedge clk) begin
    if (rst) begin
      fix_ch.ready <= 1'b0;
    end else begin
      if (fix_ch.valid && fix_ch.ready) begin
        if (fix_expected.size() == 0) begin
          failures++;
          $display("%0t fix beat with none expected: expected none actual %p",
                   $time, fix_ch.data);
        end else begin
          check_beat(fix_expected.pop_front(), fix_ch.data);
        end
      end
      if (hold_start && !hold_done) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES - 1;
        fix_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        fix_ch.ready <= 1'b0;
      end else begin
        fix_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (fix_ch.valid && fix_ch.ready))
      stall_cycles <= 0;
    else if (byte_pending.size() != 0 || fix_expected.size() != 0 || byte_ch.valid)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] s[$];
    logic [7:0] t[$];
    int         dp;
    int         np;
    int         ep;
    rst = 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all zero fields, quality zero, then separators alone
    build_sentence(0, 1'b0, 1'b0, CH_ZERO, LAYOUT_TIDY, s, dp, np, ep);
    append_text(s, ",,\r\n");
    byte_pending = {byte_pending, s};
    // all nines, south and west, top quality
    build_sentence(9, 1'b1, 1'b1, CH_EIGHT, LAYOUT_TIDY, s, dp, np, ep);
    byte_pending = {byte_pending, s};
    // quality out of range
    build_sentence(-1, 1'b0, 1'b1, CH_NINE, LAYOUT_TIDY, s, dp, np, ep);
    byte_pending = {byte_pending, s};
    // arbitrary bytes at the decimal points
    build_sentence(-1, 1'b1, 1'b0, CH_ZERO + 8'd5, LAYOUT_ODD_DOTS, s, dp, np, ep);
    byte_pending = {byte_pending, s};
    // bad hemispheres
    build_sentence(-1, 1'b1, 1'b1, CH_ZERO + 8'd6, LAYOUT_TIDY, s, dp, np, ep);
    s[np] = "X";
    byte_pending = {byte_pending, s};
    build_sentence(-1, 1'b0, 1'b0, CH_ZERO + 8'd3, LAYOUT_TIDY, s, dp, np, ep);
    s[ep] = "w";
    byte_pending = {byte_pending, s};
    // letter in a digit position
    build_sentence(-1, 1'b0, 1'b0, CH_ZERO + 8'd4, LAYOUT_TIDY, s, dp, np, ep);
    s[dp + 1] = "A";
    byte_pending = {byte_pending, s};
    // dollar inside a sentence is consumed, so the sentence after it is lost
    build_sentence(-1, 1'b1, 1'b0, CH_ZERO + 8'd2, LAYOUT_TIDY, s, dp, np, ep);
    s = s[0:dp + 1];
    s.push_back(CH_DOLLAR);
    build_sentence(-1, 1'b0, 1'b1, CH_ZERO + 8'd7, LAYOUT_TIDY, t, dp, np, ep);
    void'(t.pop_front());
    byte_pending = {byte_pending, s, t};
    // wrong talker id
    build_sentence(-1, 1'b0, 1'b0, CH_ZERO + 8'd1, LAYOUT_TIDY, s, dp, np, ep);
    s[2] = "P";
    byte_pending = {byte_pending, s};
    build_sentence(-1, 1'b1, 1'b1, CH_ZERO + 8'd1, LAYOUT_LOOSE, s, dp, np, ep);
    byte_pending = {byte_pending, s};
    drain();

    send_idle_pct = 15;
    recv_idle_pct = 80;
    queue_random_traffic(280);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 15;
    queue_random_traffic(140);
    drain();
    queue_random_traffic(140);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(300);
    hold_start = 1'b1;
    drain();

    repeat (4) @(posedge clk);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
